// ===== rtl/pbpg_pkg.sv =====
// constants, types and helpers shared by the color bar pattern byte generator
`timescale 1ns / 1ps

package pbpg_pkg;

	// frame geometry
	localparam int FRAME_WIDTH   = 800;
	localparam int FRAME_HEIGHT  = 480;
	localparam int BORDER_PIXELS = 16;
	localparam int PALETTE_COUNT = 6;

	// field widths
	localparam int IDX_W  = 20;
	localparam int PIX_W  = IDX_W + 1;
	localparam int X_W    = $clog2(FRAME_WIDTH + 1);
	localparam int Y_W    = $clog2(FRAME_HEIGHT);
	localparam int CODE_W = 4;
	localparam int BAR_W  = 3;
	localparam int CFG_W  = 32;
	localparam int CFG_IDX_W = 2;

	// bytes in one frame, two pixels a byte
	localparam int FRAME_BYTES = (FRAME_WIDTH * FRAME_HEIGHT) / 2;

	// border ring leaves nothing inside
	localparam bit BORDER_FILLS = (FRAME_WIDTH <= 2 * BORDER_PIXELS) ||
		(FRAME_HEIGHT <= 2 * BORDER_PIXELS);
	localparam int INNER_W = BORDER_FILLS ? 1 : FRAME_WIDTH - 2 * BORDER_PIXELS;

	// exact reciprocal for pixel offset / FRAME_WIDTH over the whole pixel range
	localparam int RECIP_SHIFT = PIX_W + $clog2(FRAME_WIDTH);
	localparam int RECIP_W     = PIX_W + 2;
	localparam int PROD_W      = RECIP_SHIFT + PIX_W;
	localparam longint unsigned RECIP_L =
		((64'd1 << RECIP_SHIFT) + 64'(FRAME_WIDTH) - 64'd1) / 64'(FRAME_WIDTH);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_MODE  = 2'd0,
		REG_PALETTE_CODES = 2'd1,
		REG_BLACK_CODE    = 2'd2,
		REG_WHITE_CODE    = 2'd3
	} reg_index_t;

	// reset values
	localparam logic [CFG_W-1:0]  PALETTE_RESET = 32'd6500113;
	localparam logic [CODE_W-1:0] BLACK_RESET   = 4'd0;
	localparam logic [CODE_W-1:0] WHITE_RESET   = 4'd1;

	// live configuration
	typedef struct packed {
		logic              white_mode;
		logic [CFG_W-1:0]  palette_codes;
		logic [CODE_W-1:0] black_code;
		logic [CODE_W-1:0] white_code;
	} cfg_t;

	// first inner offset that belongs to bar k
	function automatic int bar_threshold(input int k);
		return (k * INNER_W + PALETTE_COUNT - 1) / PALETTE_COUNT;
	endfunction

endpackage

// ===== rtl/pbpg_pixel.sv =====
// color code of one pixel from its coordinates
`timescale 1ns / 1ps

module pbpg_pixel (
	input  logic [pbpg_pkg::X_W-1:0]    x,
	input  logic [pbpg_pkg::Y_W-1:0]    y,
	input  pbpg_pkg::cfg_t              cfg,
	output logic [pbpg_pkg::CODE_W-1:0] code
);

	logic                        on_black;
	int                          xi;
	int                          yi;
	logic [pbpg_pkg::BAR_W-1:0]  bar;

	// border ring, right overhang and degenerate frames are black
	always_comb begin
		xi = int'(x);
		yi = int'(y);
		on_black = pbpg_pkg::BORDER_FILLS ||
			(xi >= pbpg_pkg::FRAME_WIDTH - pbpg_pkg::BORDER_PIXELS) ||
			(xi < pbpg_pkg::BORDER_PIXELS) ||
			(yi >= pbpg_pkg::FRAME_HEIGHT - pbpg_pkg::BORDER_PIXELS) ||
			(yi < pbpg_pkg::BORDER_PIXELS);
	end

	// bar index counts the thresholds passed, never beyond the last bar
	always_comb begin
		bar = '0;
		for (int k = 1; k < pbpg_pkg::PALETTE_COUNT; k++) begin
			if (xi - pbpg_pkg::BORDER_PIXELS >= pbpg_pkg::bar_threshold(k)) begin
				bar = bar + 3'd1;
			end
		end
	end

	assign code = on_black ? cfg.black_code : cfg.palette_codes[{bar, 2'b00} +: 4];

endmodule

// ===== rtl/palette_bar_pattern_byte_gen_top.sv =====
// top level of the color bar pattern byte generator
`timescale 1ns / 1ps

// Color bar test pattern source, one frame byte per word.
// Input stream: byte_index in s_axis_tdata, end-of-burst mark in s_axis_tlast.
// Output stream: pixel byte in m_axis_tdata (left pixel in the high nibble),
// in-frame flag in m_axis_tuser, burst mark echoed on m_axis_tlast.
// Each word gets exactly one result word, in order.
// Stages: input register, then reciprocal multiply for the row, column
// recovery, pixel lookup into the output register. Throughput: one word per
// cycle while m_axis_tready is high; each stage has its own ready, so bubbles
// close up and the input keeps flowing while the output register holds a
// word that is not yet taken.
// When m_axis_tready is low the output word holds and the stages behind it
// fill, after which s_axis_tready drops.
// Configuration: cfg_we/cfg_index/cfg_data write pattern mode, palette,
// black code and white code; write them only while no word is in flight.
// Reset clears all stages and loads the default colors; no clearing pass.
module palette_bar_pattern_byte_gen_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [23:0]                   s_axis_tdata,   // byte_index[19:0], zero pad
	input  logic                          s_axis_tlast,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [7:0]                    m_axis_tdata,   // pixel_byte[7:0]
	output logic                          m_axis_tuser,   // in_frame
	output logic                          m_axis_tlast,
	input  logic                          cfg_we,
	input  logic [pbpg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pbpg_pkg::CFG_W-1:0]    cfg_data
);

	pbpg_pkg::cfg_t cfg_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	logic [pbpg_pkg::IDX_W-1:0] idx_s1;
	logic                       last_s1;

	logic [pbpg_pkg::PIX_W-1:0] pix_s2;
	logic [pbpg_pkg::Y_W-1:0]   y_s2;
	logic                       inf_s2;
	logic                       last_s2;

	logic [pbpg_pkg::X_W-1:0]   x_s3;
	logic [pbpg_pkg::Y_W-1:0]   y_s3;
	logic                       inf_s3;
	logic                       last_s3;

	logic [7:0]                 byte_s4;
	logic                       inf_s4;
	logic                       last_s4;

	logic [pbpg_pkg::PIX_W-1:0]  pix_1;
	logic [pbpg_pkg::PROD_W-1:0] prod_1;
	logic                        inf_1;
	logic [pbpg_pkg::PIX_W-1:0]  row_base_2;
	logic [pbpg_pkg::PIX_W-1:0]  col_2;
	logic [pbpg_pkg::X_W-1:0]    x1_3;
	logic [pbpg_pkg::CODE_W-1:0] left_code;
	logic [pbpg_pkg::CODE_W-1:0] right_code;
	logic [7:0]                  byte_3;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.white_mode    <= 1'b0;
			cfg_q.palette_codes <= pbpg_pkg::PALETTE_RESET;
			cfg_q.black_code    <= pbpg_pkg::BLACK_RESET;
			cfg_q.white_code    <= pbpg_pkg::WHITE_RESET;
		end else if (cfg_we) begin
			unique case (pbpg_pkg::reg_index_t'(cfg_index))
				pbpg_pkg::REG_PATTERN_MODE:  cfg_q.white_mode    <= cfg_data[0];
				pbpg_pkg::REG_PALETTE_CODES: cfg_q.palette_codes <= cfg_data;
				pbpg_pkg::REG_BLACK_CODE:    cfg_q.black_code    <= cfg_data[3:0];
				pbpg_pkg::REG_WHITE_CODE:    cfg_q.white_code    <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// per stage ready: a stage moves when empty or when the next one takes
	assign rdy4          = !valid_s4 || m_axis_tready;
	assign rdy3          = !valid_s3 || rdy4;
	assign rdy2          = !valid_s2 || rdy3;
	assign rdy1          = !valid_s1 || rdy2;
	assign s_axis_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= s_axis_tvalid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
		end
	end

	// stage 1 to 2: pixel offset and row by reciprocal multiply
	always_comb begin
		pix_1  = {idx_s1, 1'b0};
		prod_1 = pbpg_pkg::PROD_W'(pix_1) * pbpg_pkg::PROD_W'(pbpg_pkg::RECIP);
		inf_1  = int'(idx_s1) < pbpg_pkg::FRAME_BYTES;
	end

	// stage 2 to 3: column is offset minus row start
	always_comb begin
		row_base_2 = pbpg_pkg::PIX_W'(y_s2) * pbpg_pkg::PIX_W'(pbpg_pkg::FRAME_WIDTH);
		col_2      = pix_s2 - row_base_2;
	end

	// stage 3 to 4: the two pixel codes
	assign x1_3 = x_s3 + pbpg_pkg::X_W'(1);

	pbpg_pixel u_left (
		.x    (x_s3),
		.y    (y_s3),
		.cfg  (cfg_q),
		.code (left_code)
	);

	pbpg_pixel u_right (
		.x    (x1_3),
		.y    (y_s3),
		.cfg  (cfg_q),
		.code (right_code)
	);

	always_comb begin
		if (!inf_s3) begin
			byte_3 = 8'h00;
		end else if (cfg_q.white_mode) begin
			byte_3 = {cfg_q.white_code, cfg_q.white_code};
		end else begin
			byte_3 = {left_code, right_code};
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (rdy1 && s_axis_tvalid) begin
			idx_s1  <= s_axis_tdata[pbpg_pkg::IDX_W-1:0];
			last_s1 <= s_axis_tlast;
		end
		if (rdy2 && valid_s1) begin
			pix_s2  <= pix_1;
			y_s2    <= prod_1[pbpg_pkg::RECIP_SHIFT +: pbpg_pkg::Y_W];
			inf_s2  <= inf_1;
			last_s2 <= last_s1;
		end
		if (rdy3 && valid_s2) begin
			x_s3    <= col_2[pbpg_pkg::X_W-1:0];
			y_s3    <= y_s2;
			inf_s3  <= inf_s2;
			last_s3 <= last_s2;
		end
		if (rdy4 && valid_s3) begin
			byte_s4 <= byte_3;
			inf_s4  <= inf_s3;
			last_s4 <= last_s3;
		end
	end

	assign m_axis_tvalid = valid_s4;
	assign m_axis_tdata  = byte_s4;
	assign m_axis_tuser  = inf_s4;
	assign m_axis_tlast  = last_s4;

endmodule
